// ----- rtl/core/qapm_pkg.sv -----
package qapm_pkg;

  typedef struct packed {
    logic signed [31:0] want_roll;
    logic signed [31:0] want_pitch;
    logic signed [31:0] want_yaw;
    logic signed [31:0] want_height;
    logic signed [31:0] meas_roll;
    logic signed [31:0] meas_pitch;
    logic signed [31:0] meas_yaw;
    logic signed [31:0] meas_height;
  } qapm_in_t;

  typedef struct packed {
    logic signed [31:0] motor_one;
    logic signed [31:0] motor_two;
    logic signed [31:0] motor_three;
    logic signed [31:0] motor_four;
    logic signed [31:0] total_thrust;
    logic signed [31:0] torque_roll;
    logic signed [31:0] torque_pitch;
    logic signed [31:0] torque_yaw;
  } qapm_out_t;

  localparam logic [2:0] REG_RP_P   = 3'd0;
  localparam logic [2:0] REG_RP_D   = 3'd1;
  localparam logic [2:0] REG_YAW_P  = 3'd2;
  localparam logic [2:0] REG_H_P    = 3'd3;
  localparam logic [2:0] REG_H_D    = 3'd4;
  localparam logic [2:0] REG_H_I    = 3'd5;
  localparam logic [2:0] REG_HOVER  = 3'd6;
  localparam logic [2:0] REG_RATE   = 3'd7;

  localparam logic [31:0] KT_Q    = 32'd922337204;
  localparam logic [31:0] L_Q     = 32'd139702023;
  localparam logic [31:0] GAMMA_Q = 32'd25340307;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    if (v > 80'sd2147483647) return 32'sh7fffffff;
    if (v < -80'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ----- rtl/core/qapm_serial_mul.sv -----
module qapm_serial_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [31:0]  b,
  output logic         done,
  output logic [95:0]  prod
);
  logic [63:0] acc_a;
  logic [31:0] sh_b;
  logic [5:0]  cnt;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_a <= a;
      sh_b  <= b;
      prod  <= '0;
    end else if (busy) begin
      prod <= {(sh_b[0] ? {1'b0, prod[95:32]} + {1'b0, acc_a} : {1'b0, prod[95:32]}),
               prod[31:1]};
      sh_b <= {1'b0, sh_b[31:1]};
    end
  end
endmodule

// ----- rtl/core/qapm_serial_div.sv -----
module qapm_serial_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [31:0]  num,
  input  logic [9:0]   den,
  output logic         done,
  output logic [31:0]  quot
);
  logic [10:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [10:0] trial;

  assign trial = {rem[9:0], quot[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem  <= trial - {1'b0, den};
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {quot[30:0], 1'b0};
      end
    end
  end
endmodule

// ----- rtl/core/quadrotor_attitude_altitude_pd_mixer.sv -----
// The next input item is taken only once the result item has been taken.
// The work is done by one shared bit-serial multiplier (19 products) and by
// a bit-serial divider for the integral step.
// Reset (rst, synchronous) restores register defaults and clears the stored
// previous errors and the height error sum.
module quadrotor_attitude_altitude_pd_mixer #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  qapm_pkg::qapm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qapm_pkg::qapm_out_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import qapm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_MIX  = 4'd3;
  localparam logic [3:0] S_OUT  = 4'd4;

  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  logic [31:0] rp_p, rp_d, yaw_p, h_p, h_d, h_i, hover;
  logic [9:0]  rate_reg;
  logic [9:0]  rate;
  logic signed [31:0] prev_h, prev_p, prev_r;
  logic signed [47:0] h_sum;
  logic signed [31:0] er, ep, ey, eh;
  logic [3:0]  state;
  logic [4:0]  op;
  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic [95:0] mul_p;
  logic [31:0] div_q;
  logic        op_neg;
  logic signed [79:0] term [0:10];
  logic signed [63:0] f_reg [0:3];
  logic signed [31:0] m_reg [0:3];
  logic signed [31:0] ch, cr, cp, cy;
  logic signed [63:0] opv;
  logic [31:0] opk;
  logic [5:0]  ops;
  logic signed [79:0] mag_shift;
  logic signed [79:0] capped;
  logic signed [63:0] ts_r, ts_p, ts_y, ts_t;

  assign rate = (rate_reg == 10'd0) ? 10'd1 : rate_reg;

  function automatic logic signed [31:0] sat_e(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    return sat32({{47{d[32]}}, d});
  endfunction

  function automatic logic signed [63:0] clamp1(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = {{32{v[31]}}, v};
    if (w > ONE) return ONE;
    if (w < -ONE) return -ONE;
    return w;
  endfunction

  always_comb begin
    er = sat_e(in_data.want_roll, in_data.meas_roll);
    ep = sat_e(in_data.want_pitch, in_data.meas_pitch);
    ey = sat_e(in_data.want_yaw, in_data.meas_yaw);
    eh = sat_e(in_data.want_height, in_data.meas_height);
  end

  logic signed [31:0] qer, qep, qey, qeh;
  logic signed [47:0] sum_new;

  always_comb begin
    opv = '0;
    opk = '0;
    ops = 6'(FRAC_BITS);
    case (op)
      5'd0: begin opv = clamp1(qeh); opk = h_p; end
      5'd1: begin opv = ({{32{qeh[31]}}, qeh} - {{32{prev_h[31]}}, prev_h})
                        * $signed({54'd0, rate}); opk = h_d; end
      5'd2: begin opv = {{16{sum_new[47]}}, sum_new}; opk = h_i; end
      5'd3: begin opv = clamp1(qer); opk = rp_p; end
      5'd4: begin opv = ({{32{qer[31]}}, qer} - {{32{prev_r[31]}}, prev_r})
                        * $signed({54'd0, rate}); opk = rp_d; end
      5'd5: begin opv = clamp1(qep); opk = rp_p; end
      5'd6: begin opv = ({{32{qep[31]}}, qep} - {{32{prev_p[31]}}, prev_p})
                        * $signed({54'd0, rate}); opk = rp_d; end
      5'd7: begin opv = clamp1(qey); opk = yaw_p; end
      5'd8, 5'd9, 5'd10, 5'd11: begin
        opv = {{32{m_reg[op[1:0]][31]}}, m_reg[op[1:0]]};
      end
      5'd12: begin opv = ts_r; opk = L_Q; ops = 6'd32; end
      5'd13: begin opv = ts_p; opk = L_Q; ops = 6'd32; end
      5'd14: begin opv = ts_y; opk = GAMMA_Q; ops = 6'd32; end
      default: ;
    endcase
  end

  // force squaring: two serial passes (m*m, then *KT)
  logic        sq_phase;
  logic [63:0] sq_val;

  always_comb begin
    mul_a = opv[63] ? 64'(-opv) : 64'(opv);
    mul_b = opk;
    if (op >= 5'd8 && op <= 5'd11) begin
      mul_a = sq_phase ? sq_val : (opv[63] ? 64'(-opv) : 64'(opv));
      mul_b = sq_phase ? KT_Q : mul_a[31:0];
    end
  end

  qapm_serial_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  qapm_serial_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(qeh[31] ? 32'(-qeh) : 32'(qeh)), .den(rate),
    .done(div_done), .quot(div_q)
  );

  always_comb begin
    logic [95:0] sh;
    sh = mul_p >> ops;
    if (sh > 96'd1099511627776) sh = 96'd1099511627776;
    mag_shift = $signed({1'b0, sh[78:0]});
    op_neg = opv[63];
    capped = op_neg ? -mag_shift : mag_shift;
  end

  always_comb begin
    ts_r = -f_reg[0] + f_reg[1] + f_reg[2] - f_reg[3];
    ts_p =  f_reg[0] + f_reg[1] - f_reg[2] - f_reg[3];
    ts_y = -f_reg[0] + f_reg[1] - f_reg[2] + f_reg[3];
    ts_t =  f_reg[0] + f_reg[1] + f_reg[2] + f_reg[3];
  end

  always_comb begin
    logic signed [79:0] s;
    s = {{48{term[0][31]}}, term[0][31:0]} + {{48{term[1][31]}}, term[1][31:0]}
      + {{48{term[2][31]}}, term[2][31:0]} + {{48{hover[31]}}, hover};
    ch = sat32(s);
    s = {{48{term[3][31]}}, term[3][31:0]} + {{48{term[4][31]}}, term[4][31:0]};
    cr = sat32(s);
    s = -{{48{term[5][31]}}, term[5][31:0]} - {{48{term[6][31]}}, term[6][31:0]};
    cp = sat32(s);
    cy = term[7][31:0];
  end

  function automatic logic signed [79:0] ext(input logic signed [31:0] v);
    return {{48{v[31]}}, v};
  endfunction

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      rp_p <= 32'd13107200; rp_d <= 32'd6553600; yaw_p <= 32'd13107200;
      h_p <= 32'd150732800; h_d <= 32'd85196800; h_i <= 32'd0;
      hover <= 32'd152698880; rate_reg <= 10'd500;
      prev_h <= '0; prev_p <= '0; prev_r <= '0; h_sum <= '0;
      state <= S_IDLE; op <= '0; out_valid <= 1'b0;
      mul_start <= 1'b0; div_start <= 1'b0; sq_phase <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_RP_P:  rp_p <= cfg_data;
          REG_RP_D:  rp_d <= cfg_data;
          REG_YAW_P: yaw_p <= cfg_data;
          REG_H_P:   h_p <= cfg_data;
          REG_H_D:   h_d <= cfg_data;
          REG_H_I:   h_i <= cfg_data;
          REG_HOVER: hover <= cfg_data;
          REG_RATE:  rate_reg <= cfg_data[9:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          qer <= er; qep <= ep; qey <= ey; qeh <= eh;
          div_start <= 1'b1;
          state <= S_DIV;
        end
        S_DIV: if (div_done) begin
          logic signed [48:0] t;
          t = {h_sum[47], h_sum} + (qeh[31] ? -$signed({17'd0, div_q})
                                              : $signed({17'd0, div_q}));
          if (t > 49'sd140737488355327) sum_new <= 48'h7fffffffffff;
          else if (t < -49'sd140737488355328) sum_new <= 48'h800000000000;
          else sum_new <= t[47:0];
          op <= '0;
          sq_phase <= 1'b0;
          mul_start <= 1'b1;
          state <= S_MUL;
        end
        S_MUL: if (mul_done) begin
          if (op >= 5'd8 && op <= 5'd11) begin
            if (!sq_phase) begin
              sq_val <= mul_p[63:0];
              sq_phase <= 1'b1;
              mul_start <= 1'b1;
            end else begin
              f_reg[op[1:0]] <= $signed({1'b0, mul_p[94:32] >> (2 * FRAC_BITS)});
              sq_phase <= 1'b0;
              op <= op + 5'd1;
              mul_start <= 1'b1;
            end
          end else begin
            if (op < 5'd8) term[op[3:0]] <= ext(sat32(capped));
            else term[op[3:0] - 4'd4] <= ext(sat32(capped));
            if (op == 5'd7) begin
              state <= S_MIX;
            end else if (op == 5'd14) begin
              state <= S_OUT;
              out_valid <= 1'b1;
            end else begin
              op <= op + 5'd1;
              mul_start <= 1'b1;
            end
          end
        end
        S_MIX: begin
          m_reg[0] <= sat32(ext(ch) - ext(cr) + ext(cp) + ext(cy));
          m_reg[1] <= sat32(ext(ch) - ext(cr) - ext(cp) - ext(cy));
          m_reg[2] <= sat32(ext(ch) + ext(cr) - ext(cp) + ext(cy));
          m_reg[3] <= sat32(ext(ch) + ext(cr) + ext(cp) - ext(cy));
          prev_h <= qeh; prev_r <= qer; prev_p <= qep; h_sum <= sum_new;
          op <= 5'd8;
          mul_start <= 1'b1;
          state <= S_MUL;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_data.motor_one    = m_reg[0];
    out_data.motor_two    = m_reg[1];
    out_data.motor_three  = m_reg[2];
    out_data.motor_four   = m_reg[3];
    out_data.total_thrust = sat32({{16{ts_t[63]}}, ts_t});
    out_data.torque_roll  = term[8][31:0];
    out_data.torque_pitch = term[9][31:0];
    out_data.torque_yaw   = term[10][31:0];
  end
endmodule

// ----- rtl/core/qapm_checker.sv -----
module qapm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("no busy after accept");
  a_noinstant: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid) else $error("result too early");
endmodule

bind quadrotor_attitude_altitude_pd_mixer qapm_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall)
);

// ----- sim/testbench.sv -----
module testbench;
  import qapm_pkg::*;

  localparam int FRAC = 16;
  localparam longint LIMIT = 6000000;
  localparam int DRAIN = 1000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  qapm_in_t in_data;
  logic out_valid;
  logic out_stall;
  qapm_out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  quadrotor_attitude_altitude_pd_mixer #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [31:0] g_rp_p, g_rp_d, g_yaw_p, g_h_p, g_h_d, g_h_i;
  longint hover, rate_reg;
  longint prev_h, prev_p, prev_r, h_sum;

  qapm_out_t mix_q[$];
  int mismatches = 0;
  longint cycles = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_cycles = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic longint sat32l(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_unit(longint v);
    longint one;
    one = longint'(1) << FRAC;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint scale_trunc(longint v, logic [31:0] k, int s);
    logic [63:0] mag;
    logic [127:0] prod;
    logic [127:0] cap;
    longint r;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    prod = {64'd0, mag} * {96'd0, k};
    prod = prod >> s;
    cap = 128'd1 << 40;
    if (prod > cap) prod = cap;
    r = longint'(prod[63:0]);
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint gain_term(longint v, logic [31:0] g);
    return sat32l(scale_trunc(v, g, FRAC));
  endfunction

  function automatic longint rotor_force(longint m);
    logic [63:0] mag;
    logic [63:0] sq;
    logic [127:0] prod;
    mag = (m < 0) ? 64'(-m) : 64'(m);
    sq = mag * mag;
    prod = {64'd0, sq} * {96'd0, KT_Q};
    prod = prod >> 32;
    if (prod > (128'd1 << 62)) prod = 128'd1 << 62;
    prod = prod >> (2 * FRAC);
    return longint'(prod[63:0]);
  endfunction

  function automatic qapm_out_t predict_mix(qapm_in_t d);
    qapm_out_t o;
    longint rt, er, ep, ey, eh, ch, cr, cp, cy, s;
    longint m[4];
    longint f[4];
    rt = (rate_reg == 0) ? 1 : rate_reg;
    er = sat32l(longint'(d.want_roll) - longint'(d.meas_roll));
    ep = sat32l(longint'(d.want_pitch) - longint'(d.meas_pitch));
    ey = sat32l(longint'(d.want_yaw) - longint'(d.meas_yaw));
    eh = sat32l(longint'(d.want_height) - longint'(d.meas_height));
    h_sum = h_sum + eh / rt;
    if (h_sum > (longint'(1) << 47) - 1) h_sum = (longint'(1) << 47) - 1;
    if (h_sum < -(longint'(1) << 47)) h_sum = -(longint'(1) << 47);
    ch = sat32l(gain_term(clamp_unit(eh), g_h_p) + gain_term((eh - prev_h) * rt, g_h_d)
                + gain_term(h_sum, g_h_i) + hover);
    cr = sat32l(gain_term(clamp_unit(er), g_rp_p) + gain_term((er - prev_r) * rt, g_rp_d));
    cp = sat32l(-gain_term(clamp_unit(ep), g_rp_p) - gain_term((ep - prev_p) * rt, g_rp_d));
    cy = gain_term(clamp_unit(ey), g_yaw_p);
    prev_h = eh;
    prev_r = er;
    prev_p = ep;
    m[0] = sat32l(ch - cr + cp + cy);
    m[1] = sat32l(ch - cr - cp - cy);
    m[2] = sat32l(ch + cr - cp + cy);
    m[3] = sat32l(ch + cr + cp - cy);
    for (int i = 0; i < 4; i++) f[i] = rotor_force(m[i]);
    o.motor_one = m[0][31:0];
    o.motor_two = m[1][31:0];
    o.motor_three = m[2][31:0];
    o.motor_four = m[3][31:0];
    s = f[0] + f[1] + f[2] + f[3];
    o.total_thrust = 32'(sat32l(s));
    s = -f[0] + f[1] + f[2] - f[3];
    o.torque_roll = 32'(sat32l(scale_trunc(s, L_Q, 32)));
    s = f[0] + f[1] - f[2] - f[3];
    o.torque_pitch = 32'(sat32l(scale_trunc(s, L_Q, 32)));
    s = -f[0] + f[1] - f[2] + f[3];
    o.torque_yaw = 32'(sat32l(scale_trunc(s, GAMMA_Q, 32)));
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** quadrotor_attitude_altitude_pd_mixer: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    qapm_out_t exp_o;
    logic [255:0] ev, av;
    if (!rst && out_valid && !out_stall) begin
      if (mix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", out_data);
      end else begin
        exp_o = mix_q.pop_front();
        ev = exp_o;
        av = out_data;
        for (int i = 0; i < 8; i++) begin
          if (ev[255 - 32*i -: 32] !== av[255 - 32*i -: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d mismatch: expected %h actual %h", i,
                       ev[255 - 32*i -: 32], av[255 - 32*i -: 32]);
          end
        end
      end
    end
  end

  task automatic send_item(input qapm_in_t d);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    mix_q.push_back(predict_mix(d));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (mix_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_RP_P: g_rp_p = val;
      REG_RP_D: g_rp_d = val;
      REG_YAW_P: g_yaw_p = val;
      REG_H_P: g_h_p = val;
      REG_H_D: g_h_d = val;
      REG_H_I: g_h_i = val;
      REG_HOVER: hover = longint'(signed'(val));
      REG_RATE: rate_reg = longint'(val[9:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    int k;
    k = $urandom_range(9);
    if (k < 4) return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
    if (k < 6) return 32'($urandom_range(0, 32'h3fffff)) - 32'h200000;
    if (k == 6) return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    return $urandom;
  endfunction

  function automatic qapm_in_t rand_item(input bit bool_near);
    qapm_in_t d;
    d.want_roll = rand_value();
    d.want_pitch = rand_value();
    d.want_yaw = rand_value();
    d.want_height = rand_value();
    if (bool_near) begin
      d.meas_roll = d.want_roll - (32'($urandom_range(0, 32'h2ffff)) - 32'h18000);
      d.meas_pitch = d.want_pitch - (32'($urandom_range(0, 32'h2ffff)) - 32'h18000);
      d.meas_yaw = d.want_yaw - (32'($urandom_range(0, 32'h2ffff)) - 32'h18000);
      d.meas_height = d.want_height - (32'($urandom_range(0, 32'h2ffff)) - 32'h18000);
    end else begin
      d.meas_roll = rand_value();
      d.meas_pitch = rand_value();
      d.meas_yaw = rand_value();
      d.meas_height = rand_value();
    end
    return d;
  endfunction

  function automatic qapm_in_t fill_item(logic [31:0] w, logic [31:0] m);
    qapm_in_t d;
    d.want_roll = w; d.want_pitch = w; d.want_yaw = w; d.want_height = w;
    d.meas_roll = m; d.meas_pitch = m; d.meas_yaw = m; d.meas_height = m;
    return d;
  endfunction

  task automatic random_config();
    write_reg(REG_RP_P, $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h0100_0000));
    write_reg(REG_RP_D, $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h0100_0000));
    write_reg(REG_YAW_P, $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h0100_0000));
    write_reg(REG_H_P, $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h1000_0000));
    write_reg(REG_H_D, $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h1000_0000));
    write_reg(REG_H_I, $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000));
    write_reg(REG_HOVER, $urandom);
    write_reg(REG_RATE, {22'($urandom_range(0, 32'h3fffff)), 10'($urandom_range(1, 1000))});
  endtask

  task automatic test_directed();
    send_item(fill_item(32'h0, 32'h0));
    send_item(fill_item(32'h7fffffff, 32'h80000000));
    send_item(fill_item(32'h80000000, 32'h7fffffff));
    send_item(fill_item(32'h00008000, 32'h0));
    send_item(fill_item(32'hffff8000, 32'h0));
    send_item(fill_item(32'h00010000, 32'h0));
    send_item(fill_item(32'h00010001, 32'h0));
    send_item(fill_item(32'h0, 32'h00020000));
    send_item(fill_item(32'h7fffffff, 32'h7fffffff));
    send_item(fill_item(32'hffffffff, 32'h00000001));
    for (int i = 0; i < 6; i++) send_item(rand_item(1'b1));
  endtask

  task automatic test_config_extremes();
    for (int i = 0; i < 6; i++) write_reg(3'(i), 32'h0);
    write_reg(REG_HOVER, 32'h0);
    write_reg(REG_RATE, 32'h0);
    send_item(fill_item(32'h00004000, 32'h0));
    send_item(fill_item(32'h7fffffff, 32'h80000000));
    for (int i = 0; i < 6; i++) write_reg(3'(i), 32'hffffffff);
    write_reg(REG_HOVER, 32'h7fffffff);
    write_reg(REG_RATE, 32'hfffffc01);
    send_item(fill_item(32'h00010000, 32'h0));
    send_item(fill_item(32'h80000000, 32'h7fffffff));
    send_item(rand_item(1'b1));
    write_reg(REG_HOVER, 32'h80000000);
    write_reg(REG_RATE, 32'h000003ff);
    send_item(fill_item(32'h00000100, 32'h0));
    send_item(rand_item(1'b0));
    write_reg(REG_RATE, {22'h2aaaaa, 10'd1000});
    send_item(fill_item(32'h7fffffff, 32'h80000000));
    send_item(rand_item(1'b1));
  endtask

  task automatic test_random(input int s_idle, input int r_idle, input int n);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) random_config();
      send_item(rand_item($urandom_range(9) < 7));
    end
  endtask

  task automatic test_backpressure();
    snd_idle = 0;
    rcv_idle = 0;
    wait_drained();
    hold_cycles = 3000;
    for (int i = 0; i < 4; i++) send_item(rand_item(1'b1));
    wait_drained();
    for (int i = 0; i < 4; i++) send_item(rand_item(1'b1));
  endtask

  initial begin
    g_rp_p = 32'd13107200;
    g_rp_d = 32'd6553600;
    g_yaw_p = 32'd13107200;
    g_h_p = 32'd150732800;
    g_h_d = 32'd85196800;
    g_h_i = 32'd0;
    hover = 152698880;
    rate_reg = 500;
    prev_h = 0;
    prev_p = 0;
    prev_r = 0;
    h_sum = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_random(22, 82, 400);
    test_random(82, 22, 400);
    test_random(0, 0, 400);
    test_backpressure();
    wait_drained();
    repeat (DRAIN) @(posedge clk);
    if (mix_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("** quadrotor_attitude_altitude_pd_mixer: PASSED **");
    end else begin
      $display("** quadrotor_attitude_altitude_pd_mixer: FAILED **");
    end
    $finish;
  end

endmodule

// ----- quadrotor_attitude_altitude_pd_mixer.f -----
rtl/core/qapm_pkg.sv
rtl/core/qapm_serial_mul.sv
rtl/core/qapm_serial_div.sv
rtl/core/quadrotor_attitude_altitude_pd_mixer.sv
rtl/core/qapm_checker.sv
sim/testbench.sv
